[hdl/assert_macros.svh]
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication under reset gating.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication under reset gating.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/ffsa_pkg.sv]
`timescale 1ns / 1ps

package ffsa_pkg;

	// Defaults for the top-level parameters
	localparam int SLOT_COUNT_DEF = 16;
	localparam int ADDR_BITS_DEF  = 32;

	// Fixed port field widths
	localparam int FIELD_W  = 32;
	localparam int USED_W   = 4;

	typedef enum logic [1:0] {
		OP_CLEAR  = 2'd0,
		OP_APPEND = 2'd1,
		OP_ALLOC  = 2'd2,
		OP_NOP    = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK     = 2'd0,
		ST_NOFIT  = 2'd1,
		ST_FULL   = 2'd2,
		ST_HALTED = 2'd3
	} status_t;

	// Controller to datapath commands
	typedef struct packed {
		logic    latch;     // capture the input transaction
		logic    clear;     // empty the table and lift the halt
		logic    append;    // write the captured slot at the fill point
		logic    set_stop;  // set the sticky halt
		logic    scan;      // read the slot after the one under test
		logic    advance;   // move to the next slot
		logic    take;      // shrink the slot under test
		logic    set_res;   // record the pending result
		status_t res_code;
		logic    post;      // move the pending result to the output register
	} ffsa_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		op_t  op;
		logic stopped;
		logic full;
		logic empty;
		logic hit;
		logic last;
		logic out_free;
	} ffsa_stat_t;

endpackage

[hdl/first_fit_slot_allocator.sv]
`timescale 1ns / 1ps
// Channel  Handshake            Payload
// input    in_valid/in_ready    operation, slot_base, amount
// output   out_valid/out_ready  status, granted_base, slot_used
//
// One transaction at a time. Clear, append and ignored operations pass through the
// execute and post states from acceptance to result; an allocate also tests the slots
// one at a time, at most SLOT_COUNT of them, as set by the single read port of the slot memory.
// A new transaction is accepted while the previous result still waits in the output
// register. Reset empties the table and lifts the halt at once; no clearing pass.
// A stalled output holds the sequencer before the next result is posted.

module first_fit_slot_allocator
	import ffsa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         operation,
	input  logic [FIELD_W-1:0] slot_base,
	input  logic [FIELD_W-1:0] amount,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] granted_base,
	output logic [USED_W-1:0]  slot_used
);

	ffsa_cmd_t  cmd;
	ffsa_stat_t stat;

	ffsa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ffsa_dp #(
		.SLOT_COUNT (SLOT_COUNT),
		.ADDR_BITS  (ADDR_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.operation    (operation),
		.slot_base    (slot_base),
		.amount       (amount),
		.cmd          (cmd),
		.stat         (stat),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_base (granted_base),
		.slot_used    (slot_used)
	);

endmodule

[hdl/ffsa_ram.sv]
`timescale 1ns / 1ps

module ffsa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write one word, read one word with a registered output
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

[hdl/ffsa_ctrl.sv]
`timescale 1ns / 1ps

module ffsa_ctrl
	import ffsa_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  ffsa_stat_t stat,
	output ffsa_cmd_t  cmd
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_EXEC,
		S_SCAN,
		S_POST
	} state_t;

	state_t state_q;

	assign in_ready = (state_q == S_IDLE);

	// Decode commands from state and datapath status
	always_comb begin
		cmd = '0;
		cmd.res_code = ST_OK;
		case (state_q)
			S_IDLE: begin
				cmd.latch = in_valid;
			end
			S_EXEC: begin
				cmd.set_res = 1'b1;
				case (stat.op)
					OP_CLEAR: begin
						cmd.clear = 1'b1;
					end
					OP_APPEND: begin
						if (stat.full) begin
							cmd.res_code = ST_FULL;
						end else begin
							cmd.append = 1'b1;
						end
					end
					OP_ALLOC: begin
						if (stat.stopped) begin
							cmd.res_code = ST_HALTED;
						end else if (stat.empty) begin
							cmd.set_stop = 1'b1;
							cmd.res_code = ST_NOFIT;
						end else begin
							// first slot is being read; result comes from the scan
							cmd.set_res = 1'b0;
						end
					end
					default: begin
						cmd.res_code = ST_OK;
					end
				endcase
			end
			S_SCAN: begin
				cmd.scan = 1'b1;
				if (stat.hit) begin
					cmd.take = 1'b1;
					cmd.set_res = 1'b1;
				end else if (stat.last) begin
					cmd.set_stop = 1'b1;
					cmd.set_res = 1'b1;
					cmd.res_code = ST_NOFIT;
				end else begin
					cmd.advance = 1'b1;
				end
			end
			S_POST: begin
				cmd.post = stat.out_free;
			end
			default: begin
				cmd = '0;
			end
		endcase
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (stat.op == OP_ALLOC && !stat.stopped && !stat.empty) begin
						state_q <= S_SCAN;
					end else begin
						state_q <= S_POST;
					end
				end
				S_SCAN: begin
					if (stat.hit || stat.last) begin
						state_q <= S_POST;
					end
				end
				S_POST: begin
					if (stat.out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

[hdl/ffsa_dp.sv]
`timescale 1ns / 1ps

module ffsa_dp
	import ffsa_pkg::*;
#(
	parameter int SLOT_COUNT = SLOT_COUNT_DEF,
	parameter int ADDR_BITS  = ADDR_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [1:0]         operation,
	input  logic [FIELD_W-1:0] slot_base,
	input  logic [FIELD_W-1:0] amount,
	input  ffsa_cmd_t          cmd,
	output ffsa_stat_t         stat,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [FIELD_W-1:0] granted_base,
	output logic [USED_W-1:0]  slot_used
);

	localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
	localparam int CNT_W = $clog2(SLOT_COUNT + 1);
	localparam int ENT_W = 2 * ADDR_BITS;

	// Captured transaction
	op_t                  op_q;
	logic [ADDR_BITS-1:0] base_q;
	logic [ADDR_BITS-1:0] amt_q;

	// Table control
	logic [CNT_W-1:0]      count_q;
	logic                  stop_q;
	logic [SLOT_COUNT-1:0] live_q;
	logic [IDX_W-1:0]      idx_q;

	// Pending result and output register
	status_t            res_status_q;
	logic [FIELD_W-1:0] res_base_q;
	logic [USED_W-1:0]  res_used_q;
	logic               out_valid_q;
	status_t            status_q;
	logic [FIELD_W-1:0] granted_q;
	logic [USED_W-1:0]  used_q;

	// Slot memory ports
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ENT_W-1:0]     wr_data;
	logic [IDX_W-1:0]     rd_addr;
	logic [ENT_W-1:0]     rd_data;
	logic [ADDR_BITS-1:0] rd_start;
	logic [ADDR_BITS-1:0] rd_size;
	logic [CNT_W-1:0]     nxt_idx;
	logic [7:0]           idx_wide;

	assign rd_start = rd_data[ENT_W-1:ADDR_BITS];
	assign rd_size  = rd_data[ADDR_BITS-1:0];
	assign nxt_idx  = CNT_W'(idx_q) + CNT_W'(1);
	assign idx_wide = 8'(idx_q);

	// Read the slot ahead of the one under test; slot zero otherwise
	assign rd_addr = cmd.scan ? nxt_idx[IDX_W-1:0] : '0;
	assign wr_en   = cmd.append | cmd.take;
	assign wr_addr = cmd.append ? count_q[IDX_W-1:0] : idx_q;
	assign wr_data = cmd.append ? {base_q, amt_q} : {rd_start + amt_q, rd_size - amt_q};

	ffsa_ram #(
		.WIDTH (ENT_W),
		.DEPTH (SLOT_COUNT)
	) u_slots (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	// Report status to the controller
	always_comb begin
		stat.op       = op_q;
		stat.stopped  = stop_q;
		stat.full     = (count_q == CNT_W'(SLOT_COUNT));
		stat.empty    = (count_q == '0);
		stat.hit      = live_q[idx_q] && (rd_size >= amt_q);
		stat.last     = (nxt_idx == count_q);
		stat.out_free = !out_valid_q || out_ready;
	end

	// Capture the transaction payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q   <= op_t'(operation);
			base_q <= ADDR_BITS'(slot_base);
			amt_q  <= ADDR_BITS'(amount);
		end
	end

	// Hold table control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			stop_q  <= 1'b0;
			live_q  <= '0;
			idx_q   <= '0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
				stop_q  <= 1'b0;
				live_q  <= '0;
			end
			if (cmd.append) begin
				count_q                     <= count_q + CNT_W'(1);
				live_q[count_q[IDX_W-1:0]] <= 1'b1;
			end
			if (cmd.set_stop) begin
				stop_q <= 1'b1;
			end
			// drop a slot that the grant empties
			if (cmd.take && rd_size == amt_q) begin
				live_q[idx_q] <= 1'b0;
			end
			if (cmd.latch) begin
				idx_q <= '0;
			end else if (cmd.advance) begin
				idx_q <= nxt_idx[IDX_W-1:0];
			end
		end
	end

	// Record the pending result
	always_ff @(posedge clk) begin
		if (cmd.set_res) begin
			res_status_q <= cmd.res_code;
			if (cmd.take) begin
				res_base_q <= FIELD_W'(rd_start);
				res_used_q <= idx_wide[USED_W-1:0];
			end else begin
				res_base_q <= '0;
				res_used_q <= '0;
			end
		end
	end

	// Output register: load on post, drop on transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.post) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.post) begin
			status_q  <= res_status_q;
			granted_q <= res_base_q;
			used_q    <= res_used_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_base = granted_q;
	assign slot_used    = used_q;

endmodule

[hdl/ffsa_checker.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ffsa_checker
	import ffsa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic [1:0]         operation,
	input logic [FIELD_W-1:0] slot_base,
	input logic [FIELD_W-1:0] amount,
	input logic               out_valid,
	input logic               out_ready,
	input logic [1:0]         status,
	input logic [FIELD_W-1:0] granted_base,
	input logic [USED_W-1:0]  slot_used
);

	// Hold a stalled result
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(status) && $stable(granted_base) && $stable(slot_used), "stalled result changed")

	// A failed result carries no grant
	`ASSERT_IMPLY(a_no_grant, clk, arst_n, out_valid && status != ST_OK, granted_base == '0 && slot_used == '0, "grant fields set on a failed result")

	// One transaction in flight at a time
	`ASSERT_NEXT(a_one_busy, clk, arst_n, in_valid && in_ready, !in_ready, "input accepted while busy")

	// No result in the cycle right after an acceptance made with the output empty
	`ASSERT_NEXT(a_no_early, clk, arst_n, in_valid && in_ready && !out_valid, !out_valid, "result posted too early")

endmodule

bind first_fit_slot_allocator ffsa_checker u_ffsa_checker (.*);
